@@ rtl/core/bmh_pkg.sv @@
package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = ADDR_W + 1;
    localparam int KEY_W    = 32;

    localparam logic [2:0] REQ_PUSH     = 3'd0;
    localparam logic [2:0] REQ_POP_ROOT = 3'd1;
    localparam logic [2:0] REQ_POP_VAL  = 3'd2;
    localparam logic [2:0] REQ_FIND     = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [KEY_W-1:0]  key_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ctrl_stat_t;

    typedef struct packed {
        logic ok;
        key_t top_key;
        cnt_t entry_count;
    } res_t;

endpackage

@@ rtl/core/binary_max_heap_engine.sv @@
// Binary max-heap of signed 32-bit keys held in a single-port-read RAM. A request is
// taken when start is high and busy is low; busy then stays high until the request
// is finished, and the result appears on ok, top_key and entry_count for exactly one
// cycle with done high, in the first cycle that busy is low again. The receiver
// cannot hold a result off. The step timing is set by the key RAM, which gives one
// registered read a cycle, and by the one key comparator that all steps share. A push
// writes the new key at the end and sifts it up, a pop root moves the last key to the
// root and sifts it down, a find scans the slots in order until a match, and a pop
// value scans, then does a pop-style sift down and sift up. At most CAPACITY-1 keys
// are held; push is refused beyond that. Clear only zeroes the count and keeps busy
// high for one cycle.
module binary_max_heap_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           req_type,
    input  logic signed [31:0]   key_value,
    output logic                 done,
    output logic                 ok,
    output logic signed [31:0]   top_key,
    output logic [10:0]          entry_count
);

    bmh_pkg::ctrl_stat_t stat;
    bmh_pkg::res_t       res;
    logic                ram_we;
    bmh_pkg::addr_t      ram_waddr;
    bmh_pkg::key_t       ram_wdata;
    bmh_pkg::addr_t      ram_raddr;
    bmh_pkg::key_t       ram_rdata;

    logic                done_reg;
    logic                ok_reg;
    bmh_pkg::key_t       top_reg;
    bmh_pkg::cnt_t       count_reg;

    bmh_ram #(
        .WIDTH (bmh_pkg::KEY_W),
        .DEPTH (bmh_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req_type  (req_type),
        .key_value (bmh_pkg::key_t'(key_value)),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .stat      (stat),
        .res       (res)
    );

    // result register: one-cycle strobe, payload held until the next transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stat.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            ok_reg    <= res.ok;
            top_reg   <= res.top_key;
            count_reg <= res.entry_count;
        end
    end

    assign busy        = stat.busy;
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign top_key     = $signed(top_reg);
    assign entry_count = 11'(count_reg);

`ifndef SYNTH
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in progress");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (entry_count <= 11'(bmh_pkg::CAPACITY - 1)))
        else $error("entry count beyond capacity");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && entry_count == '0) |-> (top_key == '0))
        else $error("empty heap reported a non-zero root");
`endif

endmodule

@@ rtl/core/bmh_ram.sv @@
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/bmh_cmp.sv @@
module bmh_cmp (
    input  bmh_pkg::key_t a,
    input  bmh_pkg::key_t b,
    output logic          lt,
    output logic          eq
);

    // keys are signed two's complement
    assign lt = $signed(a) < $signed(b);
    assign eq = (a == b);

endmodule

@@ rtl/core/bmh_ctrl.sv @@
module bmh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          req_type,
    input  bmh_pkg::key_t       key_value,
    output logic                ram_we,
    output bmh_pkg::addr_t      ram_waddr,
    output bmh_pkg::key_t       ram_wdata,
    output bmh_pkg::addr_t      ram_raddr,
    input  bmh_pkg::key_t       ram_rdata,
    output bmh_pkg::ctrl_stat_t stat,
    output bmh_pkg::res_t       res
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN_RD   = 4'd1;
    localparam logic [3:0] S_SCAN_CMP  = 4'd2;
    localparam logic [3:0] S_LAST_WAIT = 4'd3;
    localparam logic [3:0] S_SD_L      = 4'd4;
    localparam logic [3:0] S_SD_LW     = 4'd5;
    localparam logic [3:0] S_SD_RW     = 4'd6;
    localparam logic [3:0] S_SD_CMP    = 4'd7;
    localparam logic [3:0] S_SD_END    = 4'd8;
    localparam logic [3:0] S_SU_LOAD   = 4'd9;
    localparam logic [3:0] S_SU_RD     = 4'd10;
    localparam logic [3:0] S_SU_CMP    = 4'd11;
    localparam logic [3:0] S_TOP_RD    = 4'd12;
    localparam logic [3:0] S_TOP_WAIT  = 4'd13;

    localparam int CHILD_W = bmh_pkg::ADDR_W + 2;

    logic [3:0]     state_reg, state_next;
    logic [2:0]     req_reg, req_next;
    bmh_pkg::key_t  key_reg, key_next;
    bmh_pkg::cnt_t  count_reg, count_next;
    bmh_pkg::addr_t pos_reg, pos_next;
    bmh_pkg::addr_t orig_reg, orig_next;
    bmh_pkg::addr_t idx_reg, idx_next;
    bmh_pkg::addr_t cidx_reg, cidx_next;
    bmh_pkg::key_t  val_reg, val_next;
    bmh_pkg::key_t  cval_reg, cval_next;
    logic           ok_reg, ok_next;

    bmh_pkg::key_t  cmp_a;
    bmh_pkg::key_t  cmp_b;
    logic           cmp_lt;
    logic           cmp_eq;

    bmh_pkg::cnt_t     cnt_m1;
    bmh_pkg::cnt_t     idx_ext;
    logic [CHILD_W-1:0] left_idx;
    logic [CHILD_W-1:0] right_idx;
    logic [CHILD_W-1:0] count_wide;
    bmh_pkg::addr_t    pos_m1;
    bmh_pkg::addr_t    parent_idx;

    assign cnt_m1     = count_reg - 1'b1;
    assign idx_ext    = {1'b0, idx_reg};
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + 1'b1;
    assign count_wide = {1'b0, count_reg};
    assign pos_m1     = pos_reg - 1'b1;
    assign parent_idx = {1'b0, pos_m1[bmh_pkg::ADDR_W-1:1]};

    // one comparator serves the scan, the child pick and both sift directions
    always_comb
    begin
        cmp_a = ram_rdata;
        cmp_b = key_reg;
        unique case (state_reg)
            S_SD_RW:
            begin
                cmp_a = cval_reg;
                cmp_b = ram_rdata;
            end
            S_SD_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = cval_reg;
            end
            S_SU_CMP:
            begin
                cmp_a = ram_rdata;
                cmp_b = val_reg;
            end
            default:
            begin
                cmp_a = ram_rdata;
                cmp_b = key_reg;
            end
        endcase
    end

    bmh_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt),
        .eq (cmp_eq)
    );

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        orig_next  = orig_reg;
        idx_next   = idx_reg;
        cidx_next  = cidx_reg;
        val_next   = val_reg;
        cval_next  = cval_reg;
        ok_next    = ok_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = val_reg;
        ram_raddr  = '0;
        stat.busy  = (state_reg != S_IDLE);
        stat.done  = 1'b0;
        res.ok          = ok_reg;
        res.top_key     = '0;
        res.entry_count = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    key_next = key_value;
                    ok_next  = 1'b0;
                    idx_next = '0;
                    unique case (req_type) inside
                        bmh_pkg::REQ_PUSH:
                        begin
                            if (count_reg < bmh_pkg::cnt_t'(bmh_pkg::CAPACITY - 1))
                            begin
                                ok_next    = 1'b1;
                                count_next = count_reg + 1'b1;
                                pos_next   = count_reg[bmh_pkg::ADDR_W-1:0];
                                val_next   = key_value;
                                state_next = S_SU_RD;
                            end
                            else
                            begin
                                state_next = S_TOP_RD;
                            end
                        end
                        bmh_pkg::REQ_POP_ROOT:
                        begin
                            if (count_reg != '0)
                            begin
                                ok_next    = 1'b1;
                                count_next = cnt_m1;
                                pos_next   = '0;
                                ram_raddr  = cnt_m1[bmh_pkg::ADDR_W-1:0];
                                state_next = S_LAST_WAIT;
                            end
                            else
                            begin
                                state_next = S_TOP_RD;
                            end
                        end
                        bmh_pkg::REQ_POP_VAL, bmh_pkg::REQ_FIND:
                        begin
                            state_next = (count_reg != '0) ? S_SCAN_RD : S_TOP_RD;
                        end
                        bmh_pkg::REQ_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                            state_next = S_TOP_RD;
                        end
                        default:
                        begin
                            state_next = S_TOP_RD;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                ram_raddr  = idx_reg;
                state_next = S_SCAN_CMP;
            end

            S_SCAN_CMP:
            begin
                if (cmp_eq)
                begin
                    ok_next = 1'b1;
                    if (req_reg == bmh_pkg::REQ_POP_VAL)
                    begin
                        count_next = cnt_m1;
                        pos_next   = idx_reg;
                        orig_next  = idx_reg;
                        // removing the last slot needs no sift
                        if (idx_ext == cnt_m1)
                        begin
                            state_next = S_TOP_RD;
                        end
                        else
                        begin
                            ram_raddr  = cnt_m1[bmh_pkg::ADDR_W-1:0];
                            state_next = S_LAST_WAIT;
                        end
                    end
                    else
                    begin
                        state_next = S_TOP_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_ext + 1'b1 == count_reg) ? S_TOP_RD : S_SCAN_RD;
                end
            end

            S_LAST_WAIT:
            begin
                val_next   = ram_rdata;
                state_next = S_SD_L;
            end

            S_SD_L:
            begin
                if (left_idx >= count_wide)
                begin
                    ram_we     = 1'b1;
                    state_next = S_SD_END;
                end
                else
                begin
                    ram_raddr  = left_idx[bmh_pkg::ADDR_W-1:0];
                    state_next = S_SD_LW;
                end
            end

            S_SD_LW:
            begin
                cval_next = ram_rdata;
                cidx_next = left_idx[bmh_pkg::ADDR_W-1:0];
                if (right_idx < count_wide)
                begin
                    ram_raddr  = right_idx[bmh_pkg::ADDR_W-1:0];
                    state_next = S_SD_RW;
                end
                else
                begin
                    state_next = S_SD_CMP;
                end
            end

            S_SD_RW:
            begin
                // right child wins only when strictly larger
                if (cmp_lt)
                begin
                    cval_next = ram_rdata;
                    cidx_next = right_idx[bmh_pkg::ADDR_W-1:0];
                end
                state_next = S_SD_CMP;
            end

            S_SD_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_lt)
                begin
                    ram_wdata  = cval_reg;
                    pos_next   = cidx_reg;
                    state_next = S_SD_L;
                end
                else
                begin
                    state_next = S_SD_END;
                end
            end

            S_SD_END:
            begin
                if (req_reg == bmh_pkg::REQ_POP_VAL)
                begin
                    ram_raddr  = orig_reg;
                    pos_next   = orig_reg;
                    state_next = S_SU_LOAD;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end

            S_SU_LOAD:
            begin
                val_next   = ram_rdata;
                state_next = S_SU_RD;
            end

            S_SU_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = S_TOP_RD;
                end
                else
                begin
                    ram_raddr  = parent_idx;
                    state_next = S_SU_CMP;
                end
            end

            S_SU_CMP:
            begin
                ram_we = 1'b1;
                if (cmp_lt)
                begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = S_SU_RD;
                end
                else
                begin
                    state_next = S_TOP_RD;
                end
            end

            S_TOP_RD:
            begin
                if (count_reg == '0)
                begin
                    stat.done  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_raddr  = '0;
                    state_next = S_TOP_WAIT;
                end
            end

            S_TOP_WAIT:
            begin
                stat.done   = 1'b1;
                res.top_key = ram_rdata;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        key_reg  <= key_next;
        pos_reg  <= pos_next;
        orig_reg <= orig_next;
        idx_reg  <= idx_next;
        cidx_reg <= cidx_next;
        val_reg  <= val_next;
        cval_reg <= cval_next;
    end

endmodule

@@ tb/testbench.sv @@
module testbench;

    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int TAIL_CYCLES  = 64;
    localparam int QUIET_TAIL   = 100;
    localparam int POOL_SIZE    = 32;

    typedef struct {
        logic [2:0]         req;
        logic signed [31:0] key;
        bit                 wait_idle;
    } heap_req_t;

    typedef struct {
        logic               ok;
        logic signed [31:0] top_key;
        logic [10:0]        count;
    } heap_status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [2:0]         req_type = '0;
    logic signed [31:0] key_value = '0;
    logic               busy;
    logic               done;
    logic               ok;
    logic signed [31:0] top_key;
    logic [10:0]        entry_count;

    heap_req_t    request_queue[$];
    heap_status_t status_queue[$];
    heap_req_t    next_req = '{req: '0, key: '0, wait_idle: 1'b0};
    heap_status_t seen_status;
    bit           item_loaded = 1'b0;
    bit           stim_finished = 1'b0;
    int           gap_left = 0;

    // mirror of the heap
    logic signed [31:0] heap_mem [0:bmh_pkg::CAPACITY-1];
    int                 heap_cnt = 0;

    logic signed [31:0] key_pool [0:POOL_SIZE-1] = '{default: '0};
    int                 pool_wr = 0;

    int error_count   = 0;
    int sent_count    = 0;
    int checked_count = 0;
    int refused_push  = 0;
    int key_hits      = 0;
    int unused_codes  = 0;
    int peak_fill     = 0;
    int cycle_count   = 0;

    binary_max_heap_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .key_value   (key_value),
        .done        (done),
        .ok          (ok),
        .top_key     (top_key),
        .entry_count (entry_count)
    );

    always #10 clk = ~clk;

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic swap_slots(input int a, input int b);
        logic signed [31:0] t;
        t           = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endtask

    task automatic sift_down(input int pos);
        int child;
        while (pos < heap_cnt)
        begin
            child = 2 * pos + 1;
            if (child >= heap_cnt)
                break;
            if (child + 1 < heap_cnt && heap_mem[child] < heap_mem[child + 1])
                child++;
            if (!(heap_mem[pos] < heap_mem[child]))
                break;
            swap_slots(pos, child);
            pos = child;
        end
    endtask

    task automatic sift_up(input int pos);
        int up;
        while (pos != 0 && pos < heap_cnt)
        begin
            up = (pos - 1) / 2;
            if (!(heap_mem[up] < heap_mem[pos]))
                break;
            swap_slots(up, pos);
            pos = up;
        end
    endtask

    // first slot holding the key, heap_cnt when absent
    function automatic int first_slot_of(input logic signed [31:0] key);
        for (int i = 0; i < heap_cnt; i++)
            if (heap_mem[i] == key)
                return i;
        return heap_cnt;
    endfunction

    task automatic apply_heap_request(input logic [2:0] req, input logic signed [31:0] key);
        heap_status_t st;
        int           slot;
        st.ok = 1'b0;
        case (req)
            bmh_pkg::REQ_PUSH:
            begin
                if (heap_cnt < bmh_pkg::CAPACITY - 1)
                begin
                    heap_mem[heap_cnt] = key;
                    heap_cnt++;
                    sift_up(heap_cnt - 1);
                    st.ok = 1'b1;
                end
                else
                    refused_push++;
            end
            bmh_pkg::REQ_POP_ROOT:
            begin
                if (heap_cnt > 0)
                begin
                    heap_cnt--;
                    heap_mem[0] = heap_mem[heap_cnt];
                    sift_down(0);
                    st.ok = 1'b1;
                end
            end
            bmh_pkg::REQ_POP_VAL:
            begin
                slot = first_slot_of(key);
                if (slot < heap_cnt)
                begin
                    heap_cnt--;
                    // removing the last slot needs no sift
                    if (slot < heap_cnt)
                    begin
                        heap_mem[slot] = heap_mem[heap_cnt];
                        sift_down(slot);
                        sift_up(slot);
                    end
                    st.ok = 1'b1;
                    key_hits++;
                end
            end
            bmh_pkg::REQ_FIND:
            begin
                if (first_slot_of(key) < heap_cnt)
                begin
                    st.ok = 1'b1;
                    key_hits++;
                end
            end
            bmh_pkg::REQ_CLEAR:
            begin
                heap_cnt = 0;
                st.ok    = 1'b1;
            end
            default:
                unused_codes++;
        endcase
        st.top_key = (heap_cnt > 0) ? heap_mem[0] : '0;
        st.count   = 11'(heap_cnt);
        if (heap_cnt > peak_fill)
            peak_fill = heap_cnt;
        status_queue.push_back(st);
    endtask

    task automatic add_request(input logic [2:0] req, input logic signed [31:0] key);
        request_queue.push_back('{req: req, key: key, wait_idle: 1'b0});
        if (req == bmh_pkg::REQ_PUSH)
        begin
            key_pool[pool_wr % POOL_SIZE] = key;
            pool_wr++;
        end
    endtask

    task automatic add_wait();
        request_queue.push_back('{req: '0, key: '0, wait_idle: 1'b1});
    endtask

    function automatic logic signed [31:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return 32'(int'($urandom_range(0, 12)) - 6);
        if (sel < 55)
        begin
            case ($urandom_range(0, 4))
                0: return 32'sh7fff_ffff;
                1: return 32'sh8000_0000;
                2: return -32'sd1;
                3: return 32'sd0;
                default: return 32'sd1;
            endcase
        end
        if (sel < 80)
            return $urandom;
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // keys for find and pop value lean on keys already pushed
    function automatic logic signed [31:0] lookup_key();
        if ($urandom_range(0, 9) < 7)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return pick_key();
    endfunction

    initial
    begin
        int unsigned seg_left;
        int unsigned mode;
        int unsigned roll;
        int unsigned push_cut;
        int          est_fill;

        // directed: empty heap, extremes, ties, absent keys, last slot removal
        add_request(bmh_pkg::REQ_POP_ROOT, 32'sd0);
        add_request(bmh_pkg::REQ_POP_VAL, 32'sd9);
        add_request(bmh_pkg::REQ_FIND, 32'sd9);
        add_request(bmh_pkg::REQ_PUSH, 32'sd5);
        add_request(bmh_pkg::REQ_PUSH, 32'sd3);
        add_request(bmh_pkg::REQ_POP_VAL, 32'sd3);
        add_request(bmh_pkg::REQ_PUSH, 32'sh7fff_ffff);
        add_request(bmh_pkg::REQ_PUSH, 32'sh8000_0000);
        add_request(bmh_pkg::REQ_PUSH, -32'sd1);
        add_request(bmh_pkg::REQ_PUSH, 32'sd0);
        add_request(bmh_pkg::REQ_PUSH, 32'sd5);
        add_request(bmh_pkg::REQ_FIND, 32'sh8000_0000);
        add_request(bmh_pkg::REQ_FIND, 32'sd1234);
        add_request(bmh_pkg::REQ_POP_VAL, 32'sd1234);
        add_request(bmh_pkg::REQ_POP_VAL, 32'sd5);
        add_request(bmh_pkg::REQ_POP_ROOT, 32'sd0);
        add_request(3'd5, 32'sd0);
        add_request(3'd6, 32'sh5555_5555);
        add_request(3'd7, -32'sd1);
        add_request(bmh_pkg::REQ_CLEAR, 32'sd0);
        add_request(bmh_pkg::REQ_POP_ROOT, 32'sd0);
        add_request(bmh_pkg::REQ_FIND, 32'sd5);
        add_request(bmh_pkg::REQ_PUSH, 32'sd7);
        add_request(bmh_pkg::REQ_POP_ROOT, 32'sd0);
        add_request(bmh_pkg::REQ_CLEAR, 32'sd0);
        add_wait();

        // random traffic in segments that grow, shrink or mix
        seg_left = 0;
        mode     = 0;
        est_fill = 0;
        for (int i = 0; i < 675; i++)
        begin
            if (i == 340)
                add_wait();
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 60);
                mode     = $urandom_range(0, 2);
            end
            seg_left--;
            if (est_fill > 150)
                mode = 1;
            push_cut = (mode == 0) ? 60 : (mode == 1) ? 20 : 40;
            roll     = $urandom_range(0, 99);
            if (roll < push_cut)
            begin
                add_request(bmh_pkg::REQ_PUSH, pick_key());
                est_fill++;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 35)
                begin
                    add_request(bmh_pkg::REQ_POP_ROOT, $urandom);
                    if (est_fill > 0)
                        est_fill--;
                end
                else if (roll < 65)
                begin
                    add_request(bmh_pkg::REQ_POP_VAL, lookup_key());
                    if (est_fill > 0)
                        est_fill--;
                end
                else if (roll < 90)
                    add_request(bmh_pkg::REQ_FIND, lookup_key());
                else if (roll < 95)
                begin
                    add_request(bmh_pkg::REQ_CLEAR, $urandom);
                    est_fill = 0;
                end
                else
                    add_request(3'($urandom_range(5, 7)), $urandom);
            end
        end
    end

    // driver: one request transfer per start/busy handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                apply_heap_request(req_type, key_value);
                item_loaded = 1'b0;
                sent_count++;
                if (request_queue.size() > QUIET_TAIL && $urandom_range(0, 2) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            if (gap_left > 0)
                gap_left--;
            else if (!item_loaded && request_queue.size() > 0)
            begin
                if (!request_queue[0].wait_idle)
                begin
                    next_req    = request_queue.pop_front();
                    item_loaded = 1'b1;
                end
                else if (status_queue.size() == 0 && !busy)
                    request_queue.delete(0);
            end
            else if (!item_loaded)
                stim_finished = 1'b1;
            start     <= item_loaded;
            req_type  <= next_req.req;
            key_value <= next_req.key;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // monitor: results are strobed for one cycle by done
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (status_queue.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual ok=%0b top=%0d count=%0d",
                         $time, ok, top_key, entry_count);
            end
            else
            begin
                seen_status = status_queue.pop_front();
                if (^{ok, top_key, entry_count} === 1'bx)
                begin
                    error_count++;
                    $display("%0t: unknown bits in result, expected ok=%0b top=%0d count=%0d",
                             $time, seen_status.ok, seen_status.top_key, seen_status.count);
                end
                else
                begin
                    check_field("ok", seen_status.ok, ok);
                    check_field("top_key", seen_status.top_key, top_key);
                    check_field("entry_count", seen_status.count, entry_count);
                end
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, status_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (!stim_finished)
            @(posedge clk);
        while (status_queue.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("run covered %0d requests and %0d checked results, peak fill %0d of %0d",
                 sent_count, checked_count, peak_fill, bmh_pkg::CAPACITY - 1);
        $display("refused pushes %0d, key hits on find and pop value %0d, unused codes %0d",
                 refused_push, key_hits, unused_codes);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bmh_pkg.sv
rtl/core/bmh_ram.sv
rtl/core/bmh_cmp.sv
rtl/core/bmh_ctrl.sv
rtl/core/binary_max_heap_engine.sv
tb/testbench.sv
